>>> rtl/cfp_pkg.sv
package cfp_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CmdW   = 3;
  localparam int unsigned ValueW = 16;
  localparam int unsigned PhaseW = 3;
  localparam int unsigned CfgIdxW = 1;

  localparam logic [PhaseW-1:0] PH_HEADER = 3'd0;
  localparam logic [PhaseW-1:0] PH_TYPE   = 3'd1;
  localparam logic [PhaseW-1:0] PH_HIGH   = 3'd2;
  localparam logic [PhaseW-1:0] PH_LOW    = 3'd3;
  localparam logic [PhaseW-1:0] PH_TAIL   = 3'd4;

  localparam logic [CfgIdxW-1:0] REG_HEADER = 1'd0;
  localparam logic [CfgIdxW-1:0] REG_TAIL   = 1'd1;

  localparam logic [ByteW-1:0] HEADER_RST = 8'hAA;
  localparam logic [ByteW-1:0] TAIL_RST   = 8'hBB;
  localparam logic [ByteW-1:0] TYPE_LIMIT = 8'h05;

endpackage

>>> rtl/cfp_byte_if.sv
interface cfp_byte_if;
  logic                      valid;
  logic                      ready;
  logic [cfp_pkg::ByteW-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

>>> rtl/cfp_cmd_if.sv
interface cfp_cmd_if;
  logic                       valid;
  logic                       ready;
  logic [cfp_pkg::CmdW-1:0]   command;
  logic [cfp_pkg::ValueW-1:0] value;

  modport source (output valid, output command, output value, input ready);
  modport sink   (input valid, input command, input value, output ready);
endinterface

>>> rtl/command_frame_parser.sv
// Command frame parser.
// rx_i takes one received byte per beat; cmd_o gives one beat per good frame
// (header, type 0..5, value high, value low, tail) with its type and value.
// Header and tail bytes are set through the write port (index 0 header,
// index 1 tail); write them only while no byte is in flight.
// A byte is captured in an input register, then a single pass of frame
// logic updates the phase and, on a good tail, loads the output register.
// The tail byte passes the input register and then the output register before cmd_o valid rises.
// Throughput: one byte per cycle while cmd_o is not stalled, set by the single-pass phase update.
// A stall on cmd_o holds the output beat; one more byte is taken into the
// input register, then rx_i.ready drops until the output beat is taken.
// Reset clears the phase to waiting for a header, empties both registers
// and restores header 0xAA and tail 0xBB.
module command_frame_parser (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [cfp_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [cfp_pkg::ByteW-1:0]     cfg_wdata_i,
  cfp_byte_if.sink                      rx_i,
  cfp_cmd_if.source                     cmd_o
);

  logic [cfp_pkg::ByteW-1:0]  header_q, tail_q;
  logic                       in_valid_q;
  logic [cfp_pkg::ByteW-1:0]  in_byte_q;
  logic [cfp_pkg::PhaseW-1:0] phase_q, phase_d;
  logic [cfp_pkg::CmdW-1:0]   type_q, type_d;
  logic [cfp_pkg::ByteW-1:0]  high_q, high_d, low_q, low_d;
  logic                       out_valid_q;
  logic [cfp_pkg::CmdW-1:0]   cmd_q;
  logic [cfp_pkg::ValueW-1:0] value_q;
  logic                       emit;
  logic                       adv;

  assign adv         = in_valid_q && (!out_valid_q || cmd_o.ready);
  assign rx_i.ready  = !in_valid_q || adv;
  assign cmd_o.valid   = out_valid_q;
  assign cmd_o.command = cmd_q;
  assign cmd_o.value   = value_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_q <= cfp_pkg::HEADER_RST;
      tail_q   <= cfp_pkg::TAIL_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        cfp_pkg::REG_HEADER: header_q <= cfg_wdata_i;
        cfp_pkg::REG_TAIL:   tail_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (rx_i.ready) begin
      in_valid_q <= rx_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_i.valid && rx_i.ready) begin
      in_byte_q <= rx_i.rx_byte;
    end
  end

  always_comb begin
    phase_d = phase_q;
    type_d  = type_q;
    high_d  = high_q;
    low_d   = low_q;
    emit    = 1'b0;
    unique case (phase_q)
      cfp_pkg::PH_TYPE: begin
        if (in_byte_q == header_q) begin
          phase_d = cfp_pkg::PH_TYPE;
        end else if (in_byte_q > cfp_pkg::TYPE_LIMIT) begin
          phase_d = cfp_pkg::PH_HEADER;
        end else begin
          type_d  = in_byte_q[cfp_pkg::CmdW-1:0];
          phase_d = cfp_pkg::PH_HIGH;
        end
      end
      cfp_pkg::PH_HIGH: begin
        high_d  = in_byte_q;
        phase_d = cfp_pkg::PH_LOW;
      end
      cfp_pkg::PH_LOW: begin
        low_d   = in_byte_q;
        phase_d = cfp_pkg::PH_TAIL;
      end
      cfp_pkg::PH_TAIL: begin
        if (in_byte_q == header_q) begin
          phase_d = cfp_pkg::PH_TYPE;
        end else begin
          emit    = (in_byte_q == tail_q);
          phase_d = cfp_pkg::PH_HEADER;
        end
      end
      default: begin
        phase_d = (in_byte_q == header_q) ? cfp_pkg::PH_TYPE : cfp_pkg::PH_HEADER;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= cfp_pkg::PH_HEADER;
      type_q  <= '0;
      high_q  <= '0;
      low_q   <= '0;
    end else if (adv) begin
      phase_q <= phase_d;
      type_q  <= type_d;
      high_q  <= high_d;
      low_q   <= low_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= emit;
    end else if (cmd_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && emit) begin
      cmd_q   <= type_q;
      value_q <= {high_q, low_q};
    end
  end

  a_phase_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q <= cfp_pkg::PH_TAIL)
    else $error("parse phase out of range");

  a_emit_from_tail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && emit |-> phase_q == cfp_pkg::PH_TAIL && phase_d == cfp_pkg::PH_HEADER)
    else $error("result emitted outside tail phase");

  a_cmd_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> cmd_q <= cfp_pkg::TYPE_LIMIT[cfp_pkg::CmdW-1:0])
    else $error("command type out of range");

  a_in_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !adv |=> in_valid_q && $stable(in_byte_q))
    else $error("stalled input byte lost");

  a_out_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !cmd_o.ready |=> out_valid_q && $stable(value_q))
    else $error("stalled result lost");

endmodule
